/* rtl/ple_pkg.sv */
// shared types and constants for the positional list engine
// request and result payload structs, operation and status codes, sequencer states
package ple_pkg;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_REPLACE = 3'd2;
  localparam logic [2:0] OP_FIND    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found_position;
    logic [6:0] list_length;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_DRAIN,
    S_PUT,
    S_SCAN
  } state_t;

endpackage

/* rtl/ple_mem.sv */
// entry store: one write port, one read port with registered read data
// no dependencies
module ple_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/positional_list_engine_core.sv */
// Ordered list of up to CAPACITY values held in a single-port-read, single-port-write
// memory. One request is taken when start is high and busy is low; busy stays high
// until the result is produced, and done pulses for one cycle with the result, which
// cannot be held off. Out-of-range, full, clear, empty find, delete of the last entry
// and unused codes answer with done in the cycle after accept. Replace and insert at
// the end go straight to the put state; insert and delete at a position shift the
// later entries and find scans from position 0, since the sequencer moves or
// compares one entry per cycle through the memory's one read and one write port.
// depends on ple_pkg and ple_mem
module positional_list_engine_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::req_t request,
  output logic          done,
  output ple_pkg::rsp_t result
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > 7) ? CW : 7;
  localparam int FW  = (AW > 6) ? AW : 6;
  localparam int LW  = (CW > 7) ? CW : 7;

  ple_pkg::state_t state, state_next;

  logic [CW-1:0]         count, count_next;
  logic [2:0]            op_q;
  logic [AW-1:0]         pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  up_q;
  logic [AW-1:0]         rd_ptr, rd_ptr_next;
  logic [AW-1:0]         rd_last;
  logic                  rd_valid, rd_valid_next;
  logic [AW-1:0]         rd_addr, rd_addr_next;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                  accept;
  logic [PW-1:0]         pos_w, cnt_w;
  logic [AW-1:0]         in_pos;
  logic [AW-1:0]         cnt_last;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  full;

  // decode of an accepted request
  logic                  go_move, go_put, go_scan;
  logic                  imm_fin;
  logic [1:0]            imm_status;
  logic [CW-1:0]         imm_count;

  logic                  scan_hit, scan_end;
  logic                  fin;
  logic [1:0]            fin_status;
  logic [AW-1:0]         fin_found;
  logic [FW-1:0]         found_ext;
  logic [LW-1:0]         len_ext;

  assign accept   = start && (state == ple_pkg::S_IDLE);
  assign busy     = (state != ple_pkg::S_IDLE);
  assign pos_w    = PW'(request.position);
  assign cnt_w    = PW'(count);
  assign in_pos   = AW'(request.position);
  assign cnt_last = AW'(count - CW'(1));
  assign in_val   = DATA_WIDTH'($unsigned(request.value));
  assign full     = (count == CW'(CAPACITY));
  assign scan_hit = rd_valid && (mem_rdata == val_q);
  assign scan_end = rd_valid && (rd_addr == cnt_last);

  always_comb begin
    go_move    = 1'b0;
    go_put     = 1'b0;
    go_scan    = 1'b0;
    imm_fin    = 1'b0;
    imm_status = ple_pkg::ST_OK;
    imm_count  = count;
    unique case (request.operation)
      ple_pkg::OP_INSERT: begin
        if (pos_w > cnt_w) begin
          imm_fin    = 1'b1;
          imm_status = ple_pkg::ST_RANGE;
        end else if (full) begin
          imm_fin    = 1'b1;
          imm_status = ple_pkg::ST_FULL;
        end else if (pos_w == cnt_w) begin
          go_put = 1'b1;
        end else begin
          go_move = 1'b1;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (pos_w >= cnt_w) begin
          imm_fin    = 1'b1;
          imm_status = ple_pkg::ST_RANGE;
        end else if (pos_w == cnt_w - PW'(1)) begin
          imm_fin   = 1'b1;
          imm_count = count - CW'(1);
        end else begin
          go_move = 1'b1;
        end
      end
      ple_pkg::OP_REPLACE: begin
        if (pos_w >= cnt_w) begin
          imm_fin    = 1'b1;
          imm_status = ple_pkg::ST_RANGE;
        end else begin
          go_put = 1'b1;
        end
      end
      ple_pkg::OP_FIND: begin
        if (count == '0) begin
          imm_fin    = 1'b1;
          imm_status = ple_pkg::ST_NOTFOUND;
        end else begin
          go_scan = 1'b1;
        end
      end
      ple_pkg::OP_CLEAR: begin
        imm_fin   = 1'b1;
        imm_count = '0;
      end
      default: begin
        imm_fin = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          if (go_move) begin
            state_next = ple_pkg::S_MOVE;
          end else if (go_put) begin
            state_next = ple_pkg::S_PUT;
          end else if (go_scan) begin
            state_next = ple_pkg::S_SCAN;
          end
        end
      end
      ple_pkg::S_MOVE: begin
        if (rd_ptr == rd_last) begin
          state_next = ple_pkg::S_DRAIN;
        end
      end
      ple_pkg::S_DRAIN: begin
        state_next = (op_q == ple_pkg::OP_INSERT) ? ple_pkg::S_PUT : ple_pkg::S_IDLE;
      end
      ple_pkg::S_PUT: begin
        state_next = ple_pkg::S_IDLE;
      end
      ple_pkg::S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  // datapath controls and result
  always_comb begin
    count_next    = count;
    rd_ptr_next   = rd_ptr;
    rd_valid_next = 1'b0;
    rd_addr_next  = rd_addr;
    mem_we        = 1'b0;
    mem_waddr     = up_q ? rd_addr + AW'(1) : rd_addr - AW'(1);
    mem_wdata     = mem_rdata;
    fin           = 1'b0;
    fin_status    = ple_pkg::ST_OK;
    fin_found     = '0;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          fin        = imm_fin;
          fin_status = imm_status;
          count_next = imm_count;
          if (go_scan) begin
            rd_ptr_next = '0;
          end else if (request.operation == ple_pkg::OP_INSERT) begin
            rd_ptr_next = cnt_last;
          end else begin
            rd_ptr_next = in_pos + AW'(1);
          end
        end
      end
      ple_pkg::S_MOVE: begin
        // read one entry ahead, write the previous one to its new slot
        mem_we        = rd_valid;
        rd_valid_next = 1'b1;
        rd_addr_next  = rd_ptr;
        rd_ptr_next   = up_q ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
      end
      ple_pkg::S_DRAIN: begin
        mem_we = 1'b1;
        if (op_q != ple_pkg::OP_INSERT) begin
          fin        = 1'b1;
          count_next = count - CW'(1);
        end
      end
      ple_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        fin       = 1'b1;
        if (op_q == ple_pkg::OP_INSERT) begin
          count_next = count + CW'(1);
        end
      end
      ple_pkg::S_SCAN: begin
        rd_valid_next = 1'b1;
        rd_addr_next  = rd_ptr;
        rd_ptr_next   = (rd_ptr == cnt_last) ? rd_ptr : rd_ptr + AW'(1);
        if (scan_hit) begin
          fin       = 1'b1;
          fin_found = rd_addr;
        end else if (scan_end) begin
          fin        = 1'b1;
          fin_status = ple_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign found_ext = FW'(fin_found);
  assign len_ext   = LW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ple_pkg::S_IDLE;
      count    <= '0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= fin;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    rd_addr <= rd_addr_next;
    if (accept) begin
      op_q  <= request.operation;
      pos_q <= in_pos;
      val_q <= in_val;
      up_q  <= (request.operation == ple_pkg::OP_INSERT);
      // insert walks down to the slot, delete walks up to the last entry
      rd_last <= (request.operation == ple_pkg::OP_INSERT) ? in_pos : cnt_last;
    end
    if (fin) begin
      result.status         <= fin_status;
      result.found_position <= found_ext[5:0];
      result.list_length    <= len_ext[6:0];
    end
  end

  ple_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ple_pkg::S_IDLE))
    else $error("result strobe while sequencer still working");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted request neither finished nor in progress");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ple_pkg::S_IDLE))
    else $error("memory write while idle");
`endif

endmodule

/* tb/sv/positional_list_engine_core_tb.sv */
// self-checking testbench for positional_list_engine_core: directed cases, fill and drain,
// random mixes and back-to-back runs; results are predicted from a queue model of the list
// depends on ple_pkg and the positional list engine rtl
module positional_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ple_pkg::req_t request = '0;
  logic done;
  ple_pkg::rsp_t result;

  logic signed [31:0] list_model[$];
  ple_pkg::rsp_t expected_results[$];
  ple_pkg::rsp_t oldest_expected;
  int error_count = 0;
  int request_count = 0;
  int result_count = 0;
  int find_hits = 0;
  int full_rejects = 0;
  int range_rejects = 0;
  int peak_length = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  positional_list_engine_core #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(32)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one request to the list model and returns the result it must give
  function automatic ple_pkg::rsp_t apply_list_op(ple_pkg::req_t req);
    ple_pkg::rsp_t rsp;
    int pos;
    int len;
    int i;
    rsp = '0;
    pos = int'(req.position);
    len = list_model.size();
    case (req.operation)
      ple_pkg::OP_INSERT: begin
        if (pos > len) begin
          rsp.status = ple_pkg::ST_RANGE;
        end else if (len >= CAPACITY) begin
          rsp.status = ple_pkg::ST_FULL;
        end else begin
          list_model.insert(pos, req.value);
        end
      end
      ple_pkg::OP_DELETE: begin
        if (pos >= len) begin
          rsp.status = ple_pkg::ST_RANGE;
        end else begin
          list_model.delete(pos);
        end
      end
      ple_pkg::OP_REPLACE: begin
        if (pos >= len) begin
          rsp.status = ple_pkg::ST_RANGE;
        end else begin
          list_model[pos] = req.value;
        end
      end
      ple_pkg::OP_FIND: begin
        rsp.status = ple_pkg::ST_NOTFOUND;
        for (i = 0; i < len; i++) begin
          if (list_model[i] == req.value) begin
            rsp.status = ple_pkg::ST_OK;
            rsp.found_position = 6'(i);
            break;
          end
        end
      end
      ple_pkg::OP_CLEAR: begin
        list_model.delete();
      end
      default: begin
      end
    endcase
    rsp.list_length = 7'(list_model.size());
    if (rsp.status == ple_pkg::ST_FULL) full_rejects++;
    if (rsp.status == ple_pkg::ST_RANGE) range_rejects++;
    if (req.operation == ple_pkg::OP_FIND && rsp.status == ple_pkg::ST_OK) find_hits++;
    if (list_model.size() > peak_length) peak_length = list_model.size();
    return rsp;
  endfunction

  // small values make duplicates likely so find has to pick the first match
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // start stays high when the next request follows directly
  task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                              input logic [31:0] val);
    ple_pkg::req_t req;
    req.operation = op;
    req.position = pos;
    req.value = val;
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_list_op(req));
    request_count++;
  endtask

  task automatic issue(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] val);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    send_request(op, pos, val);
  endtask

  task automatic issue_random_item();
    int r;
    int len;
    logic [2:0] op;
    logic [6:0] pos;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    len = list_model.size();
    val = pick_value();
    if (r < 36) begin
      op = ple_pkg::OP_INSERT;
      pos = 7'($urandom_range(0, len));
    end else if (r < 56) begin
      op = ple_pkg::OP_DELETE;
      pos = (len > 0) ? 7'($urandom_range(0, len - 1)) : 7'd0;
    end else if (r < 70) begin
      op = ple_pkg::OP_REPLACE;
      pos = (len > 0) ? 7'($urandom_range(0, len - 1)) : 7'd0;
    end else if (r < 94) begin
      op = ple_pkg::OP_FIND;
      pos = 7'($urandom_range(0, 127));
      if (len > 0 && $urandom_range(0, 1) == 1) val = list_model[$urandom_range(0, len - 1)];
    end else if (r < 95) begin
      op = ple_pkg::OP_CLEAR;
      pos = 7'($urandom_range(0, 127));
    end else begin
      op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      pos = 7'($urandom_range(0, 127));
    end
    // some requests carry a position anywhere in the field
    if ($urandom_range(0, 99) < 8) pos = 7'($urandom_range(0, 127));
    issue(op, pos, val);
  endtask

  task automatic test_directed_cases();
    logic [2:0] op;
    idle_pct = 30;
    issue(ple_pkg::OP_DELETE, 7'd0, 32'd0);
    issue(ple_pkg::OP_REPLACE, 7'd0, 32'd5);
    issue(ple_pkg::OP_FIND, 7'd0, 32'd0);
    issue(ple_pkg::OP_INSERT, 7'd1, 32'd9);
    issue(ple_pkg::OP_INSERT, 7'd0, 32'h8000_0000);
    issue(ple_pkg::OP_INSERT, 7'd1, 32'h7fff_ffff);
    issue(ple_pkg::OP_INSERT, 7'd1, 32'hffff_ffff);
    issue(ple_pkg::OP_INSERT, 7'd0, 32'd0);
    issue(ple_pkg::OP_INSERT, 7'd4, 32'h7fff_ffff);
    // two matches: the lower position wins
    issue(ple_pkg::OP_FIND, 7'd127, 32'h7fff_ffff);
    issue(ple_pkg::OP_FIND, 7'd0, 32'h1234_5678);
    issue(ple_pkg::OP_REPLACE, 7'd0, 32'h1234_5678);
    issue(ple_pkg::OP_REPLACE, 7'd5, 32'd1);
    issue(ple_pkg::OP_DELETE, 7'd5, 32'd0);
    issue(ple_pkg::OP_DELETE, 7'd64, 32'd0);
    issue(ple_pkg::OP_INSERT, 7'd127, 32'd3);
    issue(ple_pkg::OP_DELETE, 7'd2, 32'd0);
    issue(ple_pkg::OP_DELETE, 7'd3, 32'd0);
    for (op = OP_SPARE_FIRST; op != OP_SPARE_LAST; op++) issue(op, 7'd1, 32'd7);
    issue(OP_SPARE_LAST, 7'd127, 32'hffff_ffff);
    issue(ple_pkg::OP_FIND, 7'd0, 32'h1234_5678);
    issue(ple_pkg::OP_CLEAR, 7'd0, 32'd0);
    issue(ple_pkg::OP_FIND, 7'd0, 32'd0);
    issue(ple_pkg::OP_CLEAR, 7'd127, 32'hffff_ffff);
  endtask

  task automatic test_fill_and_drain();
    int len;
    idle_pct = 25;
    while (list_model.size() < CAPACITY) begin
      issue(ple_pkg::OP_INSERT, 7'($urandom_range(0, list_model.size())), pick_value());
    end
    issue(ple_pkg::OP_INSERT, 7'($urandom_range(0, CAPACITY)), pick_value());
    issue(ple_pkg::OP_INSERT, 7'(CAPACITY), pick_value());
    // position check comes before the full check
    issue(ple_pkg::OP_INSERT, 7'(CAPACITY + 1), pick_value());
    issue(ple_pkg::OP_FIND, 7'd0, list_model[CAPACITY - 1]);
    issue(ple_pkg::OP_REPLACE, 7'(CAPACITY - 1), pick_value());
    issue(ple_pkg::OP_DELETE, 7'(CAPACITY), 32'd0);
    while (list_model.size() > 0) begin
      len = list_model.size();
      if ($urandom_range(0, 3) == 0) begin
        issue(ple_pkg::OP_FIND, 7'd0, list_model[$urandom_range(0, len - 1)]);
      end else begin
        issue(ple_pkg::OP_DELETE, 7'($urandom_range(0, len - 1)), pick_value());
      end
    end
  endtask

  task automatic test_random_mix(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 60;
        endcase
      end
      issue_random_item();
    end
  endtask

  task automatic test_back_to_back(input int count);
    int n;
    idle_pct = 0;
    for (n = 0; n < count; n++) issue_random_item();
  endtask

  // every result is taken in the cycle that done is high
  always @(posedge clk) begin
    if (!rst && done) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: %p", $time, result);
        error_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        if (result !== oldest_expected) begin
          $display("%0t: mismatch status exp %0d got %0d, found_position exp %0d got %0d, "
                   , $time, oldest_expected.status, result.status,
                   oldest_expected.found_position, result.found_position);
          $display("%0t: mismatch list_length exp %0d got %0d", $time,
                   oldest_expected.list_length, result.list_length);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still pending", $time,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fill_and_drain();
    test_random_mix(300);
    test_fill_and_drain();
    test_random_mix(300);
    test_back_to_back(150);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d results, peak length %0d, %0d full rejects,",
             request_count, result_count, peak_length, full_rejects);
    $display("%0d out-of-range rejects, %0d find hits, %0d mismatches", range_rejects,
             find_hits, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
